// ===== rtl/lbrf_pkg.sv =====
package lbrf_pkg;

  // Longest stream that the position counters track exactly.
  localparam longint unsigned MAX_STREAM_BYTES = 64'd65536;

  localparam int unsigned CNT_W = 17;
  localparam longint unsigned FIELD_MAX = (64'd1 << CNT_W) - 64'd1;

  // Saturation point of the byte counter and of the reported length.
  localparam logic [CNT_W-1:0] CAP =
    (MAX_STREAM_BYTES < FIELD_MAX) ? CNT_W'(MAX_STREAM_BYTES) : CNT_W'(FIELD_MAX);
  localparam logic [CNT_W-1:0] CAP_PAIRS = CAP - CNT_W'(1);

  typedef logic [CNT_W-1:0] cnt_t;

  // One input byte as it moves from the input register to the core.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last;
  } lbrf_item_t;

  // A run: equal pairs, 1-based start offset, byte value.
  typedef struct packed {
    cnt_t       pairs;
    cnt_t       start;
    logic [7:0] value;
  } lbrf_run_t;

endpackage

// ===== rtl/lbrf_in_reg.sv =====
module lbrf_in_reg (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_data_byte,
  input  logic               in_last,
  output logic               item_valid,
  output lbrf_pkg::lbrf_item_t item,
  input  logic               item_take
);
  import lbrf_pkg::*;

  logic       valid_r;
  lbrf_item_t item_r;
  logic       load;

  // Register is free when empty or when the core drains it this cycle.
  assign load     = !valid_r || item_take;
  assign in_stall = !load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load && in_valid) begin
      item_r.data_byte <= in_data_byte;
      item_r.last      <= in_last;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

// ===== rtl/lbrf_core.sv =====
module lbrf_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 item_valid,
  input  lbrf_pkg::lbrf_item_t item,
  output logic                 item_take,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [16:0]          out_run_start,
  output logic [7:0]           out_run_byte,
  output logic [16:0]          out_run_length
);
  import lbrf_pkg::*;

  logic [7:0] prev_byte_r;
  logic       have_prev_r;
  cnt_t       byte_count_r;
  lbrf_run_t  cur_r, cur_nxt;
  lbrf_run_t  best_r, best_nxt, best_fin;

  logic       out_valid_r;
  cnt_t       out_start_r, out_len_r;
  logic [7:0] out_byte_r;

  logic       match;
  cnt_t       byte_count_nxt;
  logic       slot_free;

  // A final byte needs the result register; other bytes never wait.
  assign slot_free = !out_valid_r || !out_stall;
  assign item_take = item_valid && (!item.last || slot_free);

  assign match = have_prev_r && (item.data_byte == prev_byte_r);
  assign byte_count_nxt = (byte_count_r < CAP) ? byte_count_r + cnt_t'(1) : byte_count_r;

  always_comb begin
    cur_nxt  = cur_r;
    best_nxt = best_r;
    if (match) begin
      if (cur_r.pairs == '0) begin
        cur_nxt.start = byte_count_r;
        cur_nxt.value = item.data_byte;
      end
      if (cur_r.pairs < CAP_PAIRS) begin
        cur_nxt.pairs = cur_r.pairs + cnt_t'(1);
      end
    end else begin
      if (cur_r.pairs > best_r.pairs) begin
        best_nxt = cur_r;
      end
      cur_nxt.pairs = '0;
    end
    // the final byte closes the open run
    best_fin = (cur_nxt.pairs > best_nxt.pairs) ? cur_nxt : best_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_byte_r  <= '0;
      have_prev_r  <= 1'b0;
      byte_count_r <= '0;
      cur_r        <= '0;
      best_r       <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (item_take) begin
        if (item.last) begin
          prev_byte_r  <= '0;
          have_prev_r  <= 1'b0;
          byte_count_r <= '0;
          cur_r        <= '0;
          best_r       <= '0;
          out_valid_r  <= 1'b1;
        end else begin
          prev_byte_r  <= item.data_byte;
          have_prev_r  <= 1'b1;
          byte_count_r <= byte_count_nxt;
          cur_r        <= cur_nxt;
          best_r       <= best_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_take && item.last) begin
      if (best_fin.pairs != '0) begin
        out_start_r <= best_fin.start;
        out_byte_r  <= best_fin.value;
        out_len_r   <= best_fin.pairs + cnt_t'(1);
      end else begin
        out_start_r <= '0;
        out_byte_r  <= '0;
        out_len_r   <= '0;
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_run_start  = out_start_r;
  assign out_run_byte   = out_byte_r;
  assign out_run_length = out_len_r;

endmodule

// ===== rtl/longest_byte_run_finder_unit.sv =====
// Channel | Dir | Handshake          | Payload
// in      | in  | in_valid/in_stall  | in_data_byte[7:0], in_last
// out     | out | out_valid/out_stall| out_run_start[16:0], out_run_byte[7:0],
//         |     |                    | out_run_length[16:0]
//
// One byte per cycle sustained while no final byte is held back; a result is
// registered after its final byte passes the input register and then
// compare/count into the result register.
// Reset (rst_n low, synchronous) empties both registers and clears run state.
// out_stall only holds back a final byte while a result is still waiting;
// ordinary bytes keep flowing under out_stall.
module longest_byte_run_finder_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [16:0] out_run_start,
  output logic [7:0]  out_run_byte,
  output logic [16:0] out_run_length
);
  import lbrf_pkg::*;

  logic       item_valid;
  lbrf_item_t item;
  logic       item_take;

  // input register: one transfer per cycle unless a held final byte blocks it, drains into the core
  lbrf_in_reg u_in (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data_byte (in_data_byte),
    .in_last      (in_last),
    .item_valid   (item_valid),
    .item         (item),
    .item_take    (item_take)
  );

  // compare with previous byte, update open/best run, load result register
  lbrf_core u_core (
    .clk            (clk),
    .rst_n          (rst_n),
    .item_valid     (item_valid),
    .item           (item),
    .item_take      (item_take),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_run_start  (out_run_start),
    .out_run_byte   (out_run_byte),
    .out_run_length (out_run_length)
  );

`ifndef ASSERT_OFF
  // "no run" result is all zeros
  a_zero_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_run_length == '0) |-> (out_run_start == '0) && (out_run_byte == '0))
    else $error("no-run result carries nonzero start or byte");

  // a real run has at least two bytes and a 1-based start
  a_run_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_run_length != '0) |-> (out_run_length >= 17'd2) && (out_run_start != '0)
      && (out_run_length <= CAP))
    else $error("malformed run result");

  // a waiting result is never dropped
  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("stalled result lost");

  // input side stalls only while its register is occupied and blocked
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> item_valid && item.last && out_valid && out_stall)
    else $error("input stalled without a blocked final byte");
`endif

endmodule
